FILE: hdl/job_scheduler_with_aging_top_macros.svh
// Assertion macros for the scheduler checker.
`ifndef JOB_SCHEDULER_WITH_AGING_TOP_MACROS_SVH
`define JOB_SCHEDULER_WITH_AGING_TOP_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define JSA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// Antecedent implies consequent in the next cycle.
`define JSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

FILE: hdl/jsa_pkg.sv
// Shared types and constants of the job scheduler with aging.
`default_nettype none
package jsa_pkg;
    localparam int PRI_W  = 4;
    localparam int TIME_W = 16;
    localparam int WAIT_W = 20;
    localparam int FID_W  = 16;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 20;

    localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

    localparam logic [1:0]        POLICY_RST    = 2'd3;
    localparam logic [TIME_W-1:0] WAIT_STEP_RST = 16'd100;
    localparam logic [WAIT_W-1:0] THRESH_RST    = 20'd1000;
    localparam logic [PRI_W-1:0]  CAP_RST       = 4'd3;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_ENQ  = 2'd1,
        ACT_DEQ  = 2'd2,
        ACT_EXIT = 2'd3
    } jsa_action_t;

    typedef enum logic [1:0] {
        POL_PRIO  = 2'd0,
        POL_ID    = 2'd1,
        POL_SHORT = 2'd2,
        POL_RATIO = 2'd3
    } jsa_policy_t;

    typedef enum logic [1:0] {
        REG_POLICY    = 2'd0,
        REG_WAIT_STEP = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_CAP       = 2'd3
    } jsa_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACT,
        ST_DQ_RD,
        ST_DQ_EV,
        ST_RM_RD,
        ST_RM_WR,
        ST_AG_RD,
        ST_AG_EV,
        ST_AG_WR,
        ST_AG_DIV,
        ST_REL,
        ST_FIN,
        ST_DONE
    } jsa_state_t;
endpackage
`default_nettype wire

FILE: hdl/jsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module jsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/jsa_div.sv
// Restoring divider, one quotient bit per cycle: wait over declared time.
`default_nettype none
module jsa_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [jsa_pkg::WAIT_W-1:0]  dividend,
    input  wire logic [jsa_pkg::TIME_W-1:0]  divisor,
    output logic                             done,
    output logic      [jsa_pkg::WAIT_W-1:0]  quotient
);
    import jsa_pkg::*;

    localparam int CW = $clog2(WAIT_W + 1);

    logic [TIME_W:0]   rem_reg, rem_next;
    logic [WAIT_W-1:0] quo_reg, quo_next;
    logic [TIME_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [TIME_W:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg[TIME_W-1:0], quo_reg[WAIT_W-1]};
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = CW'(WAIT_W);
        end else if (cnt_reg != '0) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[WAIT_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[WAIT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

FILE: hdl/job_scheduler_with_aging_top.sv
// Top level of the job scheduler with aging: sequencer, queue RAM and divider.
//
// The block keeps an ordered ready queue of up to QUEUE_DEPTH jobs in a RAM
// and one running job in registers. Each input item applies one action
// (tick, enqueue, dequeue by id, exit of the running job); every action but
// exit then ages all queued jobs and picks a job under the configured policy,
// which takes over the running slot and sends any preempted job to the queue
// tail. One result item comes out per input item. The block handles one item
// at a time and is not ready while it works. A dequeue scans the queue entry
// by entry (read, then compare), a removal shifts the later entries down one
// by one (read, then write), and aging walks every queued entry (read, age,
// write back); under the response-ratio policy every queued job also waits on
// the shared 20-step divider. Exit items skip the aging pass. A finished
// result waits in the output register; the next item is accepted once the
// sequencer is idle again. Configuration writes are always taken and take
// effect at once, also on an item in progress.
`default_nettype none
module job_scheduler_with_aging_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 16
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // input items
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_action,
    input  wire logic [jsa_pkg::PRI_W-1:0]  s_job_priority,
    input  wire logic [jsa_pkg::TIME_W-1:0] s_job_time,
    input  wire logic [jsa_pkg::FID_W-1:0]  s_target_id,
    // result items
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic                            m_running_valid,
    output logic      [jsa_pkg::FID_W-1:0]  m_running_id,
    output logic                            m_switched,
    output logic                            m_preempted_valid,
    output logic      [jsa_pkg::FID_W-1:0]  m_preempted_id,
    output logic      [jsa_pkg::FID_W-1:0]  m_new_id,
    output logic                            m_queue_full,
    output logic                            m_removed,
    output logic      [jsa_pkg::CNT_W-1:0]  m_queue_count,
    // configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [jsa_pkg::CFG_W-1:0]  cfg_data
);
    import jsa_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int KW = (ID_BITS > WAIT_W) ? ID_BITS : WAIT_W;
    localparam int RW = ID_BITS + 2 * PRI_W + TIME_W + WAIT_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(QUEUE_DEPTH);

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [PRI_W-1:0]   defpri;
        logic [PRI_W-1:0]   curpri;
        logic [TIME_W-1:0]  dtime;
        logic [WAIT_W-1:0]  wait_cnt;
    } job_t;

    function automatic logic [FID_W-1:0] fid(input logic [ID_BITS-1:0] v);
        logic [ID_BITS+FID_W-1:0] ext;
        ext = (ID_BITS + FID_W)'(v);
        return ext[FID_W-1:0];
    endfunction

    function automatic logic id_eq(input logic [ID_BITS-1:0] a, input logic [FID_W-1:0] b);
        return (ID_BITS + FID_W)'(a) == (ID_BITS + FID_W)'(b);
    endfunction

    // State
    jsa_state_t         state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [LW-1:0]      idx_reg, idx_next;
    logic [LW-1:0]      rm_pos_reg, rm_pos_next;
    logic               rm_sel_reg, rm_sel_next;
    logic [LW-1:0]      best_pos_reg, best_pos_next;
    logic               found_reg, found_next;
    logic [KW-1:0]      key_reg, key_next;
    job_t               best_reg, best_next;
    job_t               aged_reg, aged_next;
    logic               run_pres_reg, run_pres_next;
    logic               run_done_reg, run_done_next;
    job_t               run_reg, run_next;
    logic [ID_BITS-1:0] id_ctr_reg, id_ctr_next;
    logic [1:0]         act_reg, act_next;
    logic [PRI_W-1:0]   prio_reg, prio_next;
    logic [TIME_W-1:0]  jtime_reg, jtime_next;
    logic [FID_W-1:0]   target_reg, target_next;
    logic               sw_reg, sw_next;
    logic               pre_v_reg, pre_v_next;
    logic [FID_W-1:0]   pre_id_reg, pre_id_next;
    logic [FID_W-1:0]   new_id_reg, new_id_next;
    logic               full_reg, full_next;
    logic               removed_reg, removed_next;
    logic [1:0]         policy_reg, policy_next;
    logic [TIME_W-1:0]  wstep_reg, wstep_next;
    logic [WAIT_W-1:0]  thr_reg, thr_next;
    logic [PRI_W-1:0]   cap_reg, cap_next;
    logic               m_valid_reg, m_valid_next;
    logic               o_run_v_reg, o_run_v_next;
    logic [FID_W-1:0]   o_run_id_reg, o_run_id_next;
    logic               o_sw_reg, o_sw_next;
    logic               o_pre_v_reg, o_pre_v_next;
    logic [FID_W-1:0]   o_pre_id_reg, o_pre_id_next;
    logic [FID_W-1:0]   o_new_id_reg, o_new_id_next;
    logic               o_full_reg, o_full_next;
    logic               o_removed_reg, o_removed_next;
    logic [CNT_W-1:0]   o_cnt_reg, o_cnt_next;

    // RAM and divider hookup
    logic               ram_we;
    logic [QW-1:0]      ram_waddr;
    logic [QW-1:0]      ram_raddr;
    job_t               ram_wdata;
    logic [RW-1:0]      ram_rdata_bits;
    job_t               ram_rdata;
    logic               div_start;
    logic               div_done;
    logic [WAIT_W-1:0]  div_quo;
    logic [TIME_W-1:0]  div_dvs;

    // Aging and selection datapath
    job_t               aged_c;
    logic [WAIT_W:0]    wait_sum;
    logic [KW-1:0]      cand_key;
    logic               better;
    logic               start_age;
    logic               advance;
    logic [LW+CNT_W-1:0] len_ext;

    jsa_ram #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = job_t'(ram_rdata_bits);
    assign div_dvs   = (aged_reg.dtime == '0) ? TIME_W'(1) : aged_reg.dtime;

    jsa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (aged_reg.wait_cnt),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Age one record read from the queue: saturating wait, then priority bump.
    always_comb begin
        aged_c   = ram_rdata;
        wait_sum = (WAIT_W + 1)'(ram_rdata.wait_cnt) + (WAIT_W + 1)'(wstep_reg);
        aged_c.wait_cnt = wait_sum[WAIT_W] ? WAIT_MAX : wait_sum[WAIT_W-1:0];
        if (aged_c.wait_cnt >= thr_reg && ram_rdata.curpri < cap_reg) begin
            aged_c.curpri = ram_rdata.curpri + PRI_W'(1);
        end
    end

    // Policy compare of the aged record against the best so far; earliest wins ties.
    always_comb begin
        cand_key = '0;
        better   = 1'b0;
        case (policy_reg)
            POL_PRIO: begin
                cand_key = KW'(aged_reg.curpri);
                better   = !found_reg || cand_key > key_reg;
            end
            POL_ID: begin
                cand_key = KW'(aged_reg.id);
                better   = !found_reg || cand_key < key_reg;
            end
            POL_SHORT: begin
                cand_key = KW'(aged_reg.dtime);
                better   = !found_reg || cand_key < key_reg;
            end
            default: begin
                cand_key = KW'(div_quo);
                better   = cand_key > key_reg;
            end
        endcase
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign len_ext   = (LW + CNT_W)'(len_reg);

    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        rm_pos_next   = rm_pos_reg;
        rm_sel_next   = rm_sel_reg;
        best_pos_next = best_pos_reg;
        found_next    = found_reg;
        key_next      = key_reg;
        best_next     = best_reg;
        aged_next     = aged_reg;
        run_pres_next = run_pres_reg;
        run_done_next = run_done_reg;
        run_next      = run_reg;
        id_ctr_next   = id_ctr_reg;
        act_next      = act_reg;
        prio_next     = prio_reg;
        jtime_next    = jtime_reg;
        target_next   = target_reg;
        sw_next       = sw_reg;
        pre_v_next    = pre_v_reg;
        pre_id_next   = pre_id_reg;
        new_id_next   = new_id_reg;
        full_next     = full_reg;
        removed_next  = removed_reg;
        policy_next   = policy_reg;
        wstep_next    = wstep_reg;
        thr_next      = thr_reg;
        cap_next      = cap_reg;
        m_valid_next  = m_valid_reg;
        o_run_v_next  = o_run_v_reg;
        o_run_id_next = o_run_id_reg;
        o_sw_next     = o_sw_reg;
        o_pre_v_next  = o_pre_v_reg;
        o_pre_id_next = o_pre_id_reg;
        o_new_id_next = o_new_id_reg;
        o_full_next   = o_full_reg;
        o_removed_next = o_removed_reg;
        o_cnt_next    = o_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = aged_reg;
        ram_raddr     = '0;
        div_start     = 1'b0;
        start_age     = 1'b0;
        advance       = 1'b0;

        // configuration writes land at once
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_POLICY:    policy_next = cfg_data[1:0];
                REG_WAIT_STEP: wstep_next  = cfg_data[TIME_W-1:0];
                REG_THRESHOLD: thr_next    = cfg_data[WAIT_W-1:0];
                REG_CAP:       cap_next    = cfg_data[PRI_W-1:0];
                default: ;
            endcase
        end

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next     = s_action;
                    prio_next    = s_job_priority;
                    jtime_next   = s_job_time;
                    target_next  = s_target_id;
                    sw_next      = 1'b0;
                    pre_v_next   = 1'b0;
                    pre_id_next  = '0;
                    new_id_next  = '0;
                    full_next    = 1'b0;
                    removed_next = 1'b0;
                    state_next   = ST_ACT;
                end
            end
            ST_ACT: begin
                unique case (act_reg)
                    ACT_EXIT: begin
                        if (run_pres_reg) begin
                            run_done_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end
                    ACT_ENQ: begin
                        if (len_reg == DEPTH_L) begin
                            full_next = 1'b1;
                        end else begin
                            id_ctr_next        = id_ctr_reg + ID_BITS'(1);
                            ram_we             = 1'b1;
                            ram_waddr          = len_reg[QW-1:0];
                            ram_wdata.id       = id_ctr_next;
                            ram_wdata.defpri   = prio_reg;
                            ram_wdata.curpri   = prio_reg;
                            ram_wdata.dtime    = jtime_reg;
                            ram_wdata.wait_cnt = '0;
                            new_id_next        = fid(id_ctr_next);
                            len_next           = len_reg + LW'(1);
                        end
                        start_age = 1'b1;
                    end
                    ACT_DEQ: begin
                        // the running job, even an exited one, is matched first
                        if (run_pres_reg && id_eq(run_reg.id, target_reg)) begin
                            run_pres_next = 1'b0;
                            run_done_next = 1'b0;
                            removed_next  = 1'b1;
                            start_age     = 1'b1;
                        end else if (len_reg == '0) begin
                            start_age = 1'b1;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_DQ_RD;
                        end
                    end
                    default: begin
                        start_age = 1'b1;
                    end
                endcase
            end
            ST_DQ_RD: begin
                ram_raddr  = idx_reg[QW-1:0];
                state_next = ST_DQ_EV;
            end
            ST_DQ_EV: begin
                if (id_eq(ram_rdata.id, target_reg)) begin
                    removed_next = 1'b1;
                    rm_pos_next  = idx_reg;
                    rm_sel_next  = 1'b0;
                    state_next   = ST_RM_RD;
                end else if (idx_reg + LW'(1) == len_reg) begin
                    start_age = 1'b1;
                end else begin
                    idx_next   = idx_reg + LW'(1);
                    state_next = ST_DQ_RD;
                end
            end
            ST_RM_RD: begin
                // close the gap one entry at a time, then shorten the queue
                if (rm_pos_reg + LW'(1) >= len_reg) begin
                    len_next = len_reg - LW'(1);
                    if (rm_sel_reg) begin
                        state_next = ST_FIN;
                    end else begin
                        start_age = 1'b1;
                    end
                end else begin
                    ram_raddr  = rm_pos_next[QW-1:0] + QW'(1);
                    state_next = ST_RM_WR;
                end
            end
            ST_RM_WR: begin
                ram_we      = 1'b1;
                ram_waddr   = rm_pos_reg[QW-1:0];
                ram_wdata   = ram_rdata;
                rm_pos_next = rm_pos_reg + LW'(1);
                state_next  = ST_RM_RD;
            end
            ST_AG_RD: begin
                ram_raddr  = idx_reg[QW-1:0];
                state_next = ST_AG_EV;
            end
            ST_AG_EV: begin
                aged_next  = aged_c;
                state_next = ST_AG_WR;
            end
            ST_AG_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[QW-1:0];
                ram_wdata = aged_reg;
                if (policy_reg == POL_RATIO) begin
                    div_start  = 1'b1;
                    state_next = ST_AG_DIV;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_AG_DIV: begin
                if (div_done) begin
                    advance = 1'b1;
                end
            end
            ST_REL: begin
                // release an exited job before the pick takes over
                if (run_pres_reg && run_done_reg) begin
                    run_pres_next = 1'b0;
                    run_done_next = 1'b0;
                end
                if (found_reg) begin
                    rm_pos_next = best_pos_reg;
                    rm_sel_next = 1'b1;
                    state_next  = ST_RM_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FIN: begin
                if (run_pres_reg) begin
                    ram_we             = 1'b1;
                    ram_waddr          = len_reg[QW-1:0];
                    ram_wdata          = run_reg;
                    ram_wdata.curpri   = run_reg.defpri;
                    ram_wdata.wait_cnt = '0;
                    len_next           = len_reg + LW'(1);
                    pre_v_next         = 1'b1;
                    pre_id_next        = fid(run_reg.id);
                end
                run_next      = best_reg;
                run_pres_next = 1'b1;
                run_done_next = 1'b0;
                sw_next       = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    o_run_v_next   = run_pres_reg && !run_done_reg;
                    o_run_id_next  = o_run_v_next ? fid(run_reg.id) : '0;
                    o_sw_next      = sw_reg;
                    o_pre_v_next   = pre_v_reg;
                    o_pre_id_next  = pre_id_reg;
                    o_new_id_next  = new_id_reg;
                    o_full_next    = full_reg;
                    o_removed_next = removed_reg;
                    o_cnt_next     = len_ext[CNT_W-1:0];
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // one queued job aged and weighed: keep the better one, advance
        if (advance) begin
            if (better) begin
                found_next    = 1'b1;
                key_next      = cand_key;
                best_pos_next = idx_reg;
                best_next     = aged_reg;
            end
            if (idx_reg + LW'(1) == len_reg) begin
                state_next = ST_REL;
            end else begin
                idx_next   = idx_reg + LW'(1);
                state_next = ST_AG_RD;
            end
        end

        // open the aging and selection pass
        if (start_age) begin
            idx_next   = '0;
            found_next = 1'b0;
            key_next   = '0;
            state_next = (len_next == '0) ? ST_REL : ST_AG_RD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            len_reg      <= '0;
            run_pres_reg <= 1'b0;
            run_done_reg <= 1'b0;
            id_ctr_reg   <= '0;
            m_valid_reg  <= 1'b0;
            policy_reg   <= POLICY_RST;
            wstep_reg    <= WAIT_STEP_RST;
            thr_reg      <= THRESH_RST;
            cap_reg      <= CAP_RST;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            run_pres_reg <= run_pres_next;
            run_done_reg <= run_done_next;
            id_ctr_reg   <= id_ctr_next;
            m_valid_reg  <= m_valid_next;
            policy_reg   <= policy_next;
            wstep_reg    <= wstep_next;
            thr_reg      <= thr_next;
            cap_reg      <= cap_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        rm_pos_reg    <= rm_pos_next;
        rm_sel_reg    <= rm_sel_next;
        best_pos_reg  <= best_pos_next;
        found_reg     <= found_next;
        key_reg       <= key_next;
        best_reg      <= best_next;
        aged_reg      <= aged_next;
        run_reg       <= run_next;
        act_reg       <= act_next;
        prio_reg      <= prio_next;
        jtime_reg     <= jtime_next;
        target_reg    <= target_next;
        sw_reg        <= sw_next;
        pre_v_reg     <= pre_v_next;
        pre_id_reg    <= pre_id_next;
        new_id_reg    <= new_id_next;
        full_reg      <= full_next;
        removed_reg   <= removed_next;
        o_run_v_reg   <= o_run_v_next;
        o_run_id_reg  <= o_run_id_next;
        o_sw_reg      <= o_sw_next;
        o_pre_v_reg   <= o_pre_v_next;
        o_pre_id_reg  <= o_pre_id_next;
        o_new_id_reg  <= o_new_id_next;
        o_full_reg    <= o_full_next;
        o_removed_reg <= o_removed_next;
        o_cnt_reg     <= o_cnt_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_running_valid   = o_run_v_reg;
    assign m_running_id      = o_run_id_reg;
    assign m_switched        = o_sw_reg;
    assign m_preempted_valid = o_pre_v_reg;
    assign m_preempted_id    = o_pre_id_reg;
    assign m_new_id          = o_new_id_reg;
    assign m_queue_full      = o_full_reg;
    assign m_removed         = o_removed_reg;
    assign m_queue_count     = o_cnt_reg;
endmodule
`default_nettype wire

FILE: hdl/jsa_chk.sv
// Port-level checker for the job scheduler, bound to the top level.
`default_nettype none
`include "job_scheduler_with_aging_top_macros.svh"
module jsa_chk (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic                       m_running_valid,
    input wire logic [jsa_pkg::FID_W-1:0]  m_running_id,
    input wire logic                       m_switched,
    input wire logic                       m_preempted_valid,
    input wire logic [jsa_pkg::FID_W-1:0]  m_preempted_id,
    input wire logic [jsa_pkg::FID_W-1:0]  m_new_id,
    input wire logic                       m_queue_full
);
    `JSA_ASSERT_NEXT(a_hold_result, m_valid && !m_ready, m_valid)
    `JSA_ASSERT_SAME(a_idle_id_zero, m_valid && !m_running_valid, m_running_id == '0)
    `JSA_ASSERT_SAME(a_preempt_needs_switch, m_valid && m_preempted_valid, m_switched && m_running_valid)
    `JSA_ASSERT_SAME(a_full_no_id, m_valid && m_queue_full, m_new_id == '0)
    `JSA_ASSERT_SAME(a_no_preempt_id, m_valid && !m_preempted_valid, m_preempted_id == '0)
endmodule

bind job_scheduler_with_aging_top jsa_chk u_jsa_chk (.*);
`default_nettype wire
